// File: hw/rtl/epe_pkg.sv
package epe_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int WIDE_W    = 66;
    localparam int NSTAGE    = 7;
    localparam int CFG_IDX_W = 3;

    localparam int TS_W   = 17;
    localparam int REST_W = 17;
    localparam int DRAG_W = 20;
    localparam int AGE_W  = 17;

    // Raw product widths: value, age x step; drag, gravity, bounce x value.
    localparam int PP_W = DATA_W + TS_W + 1;
    localparam int PL_W = AGE_W + TS_W;
    localparam int PD_W = DATA_W + DRAG_W + 1;
    localparam int PG_W = 2 * DATA_W;
    localparam int PB_W = DATA_W + REST_W + 1;

    typedef logic signed [DATA_W-1:0] fix_t;
    typedef logic signed [WIDE_W-1:0] wide_t;

    localparam wide_t WIDE_ONE  = wide_t'(1) << FRAC_BITS;
    localparam wide_t WIDE_HALF = wide_t'(1) << (FRAC_BITS - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIME_STEP   = 3'd0,
        REG_GROUND      = 3'd1,
        REG_RESTITUTION = 3'd2,
        REG_DRAG        = 3'd3,
        REG_WIND_X      = 3'd4,
        REG_WIND_Y      = 3'd5,
        REG_WIND_Z      = 3'd6,
        REG_GRAVITY_Y   = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic        [TS_W-1:0]   time_step;
        logic signed [DATA_W-1:0] ground_level;
        logic        [REST_W-1:0] bounce_restitution;
        logic        [DRAG_W-1:0] drag_gain;
        logic signed [DATA_W-1:0] wind_x;
        logic signed [DATA_W-1:0] wind_y;
        logic signed [DATA_W-1:0] wind_z;
        logic signed [DATA_W-1:0] gravity_y;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        time_step:          17'd1092,
        ground_level:       -32'sd655360,
        bounce_restitution: 17'd49152,
        drag_gain:          20'd32768,
        wind_x:             32'sd2018509,
        wind_y:             32'sd353894,
        wind_z:             32'sd13107,
        gravity_y:          -32'sd1952973
    };

    typedef struct packed {
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] pos_z;
        logic signed [DATA_W-1:0] vel_x;
        logic signed [DATA_W-1:0] vel_y;
        logic signed [DATA_W-1:0] vel_z;
        logic signed [DATA_W-1:0] life_left;
        logic        [AGE_W-1:0]  aging_rate;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] new_pos_x;
        logic signed [DATA_W-1:0] new_pos_y;
        logic signed [DATA_W-1:0] new_pos_z;
        logic signed [DATA_W-1:0] new_vel_x;
        logic signed [DATA_W-1:0] new_vel_y;
        logic signed [DATA_W-1:0] new_vel_z;
        logic signed [DATA_W-1:0] new_life;
        logic                     bounced;
        logic                     saturated;
    } result_t;

    // Handed from the front half to the back half of the pipeline.
    typedef struct packed {
        fix_t pos_x;
        fix_t pos_y;
        fix_t pos_z;
        fix_t vel_x;
        fix_t vel_y;
        fix_t vel_z;
        fix_t acc_x;
        fix_t acc_y;
        fix_t acc_z;
        fix_t life;
        fix_t gdiff;
        logic bounce;
        logic clip;
    } mid_t;

    typedef struct packed {
        logic [NSTAGE:1] load;
    } stage_ctl_t;

    typedef struct packed {
        fix_t val;
        logic clip;
    } sat_t;

    function automatic sat_t sat_fix(input wide_t x);
        sat_t  r;
        wide_t hi;
        wide_t lo;
        hi = {{(WIDE_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
        lo = ~hi;
        if (x > hi) begin
            r.val  = {1'b0, {(DATA_W - 1){1'b1}}};
            r.clip = 1'b1;
        end else if (x < lo) begin
            r.val  = {1'b1, {(DATA_W - 1){1'b0}}};
            r.clip = 1'b1;
        end else begin
            r.val  = x[DATA_W-1:0];
            r.clip = 1'b0;
        end
        return r;
    endfunction

    // Round half up to FRAC_BITS fraction bits, then saturate.
    function automatic sat_t round_sat(input wide_t p);
        wide_t t;
        t = (p + WIDE_HALF) >>> FRAC_BITS;
        return sat_fix(t);
    endfunction

endpackage

// File: hw/rtl/epe_cfg_regs.sv
module epe_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [epe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [epe_pkg::DATA_W-1:0]       cfg_data,
    output epe_pkg::cfg_t                    cfg
);

    epe_pkg::cfg_t cfg_reg;
    epe_pkg::cfg_t cfg_next;
    logic          wr_en;

    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid && cfg_ready;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (epe_pkg::cfg_reg_t'(cfg_index))
                epe_pkg::REG_TIME_STEP:
                    cfg_next.time_step = cfg_data[epe_pkg::TS_W-1:0];
                epe_pkg::REG_GROUND:
                    cfg_next.ground_level = cfg_data;
                epe_pkg::REG_RESTITUTION:
                    cfg_next.bounce_restitution = cfg_data[epe_pkg::REST_W-1:0];
                epe_pkg::REG_DRAG:
                    cfg_next.drag_gain = cfg_data[epe_pkg::DRAG_W-1:0];
                epe_pkg::REG_WIND_X:
                    cfg_next.wind_x = cfg_data;
                epe_pkg::REG_WIND_Y:
                    cfg_next.wind_y = cfg_data;
                epe_pkg::REG_WIND_Z:
                    cfg_next.wind_z = cfg_data;
                epe_pkg::REG_GRAVITY_Y:
                    cfg_next.gravity_y = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= epe_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: hw/rtl/epe_pipe_ctrl.sv
module epe_pipe_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    output logic                 result_valid,
    input  logic                 result_stall,
    output epe_pkg::stage_ctl_t  ctl
);

    logic [epe_pkg::NSTAGE:1] valid_reg;
    logic [epe_pkg::NSTAGE:1] valid_next;
    logic [epe_pkg::NSTAGE:1] valid_in;
    logic [epe_pkg::NSTAGE:1] rdy;

    // A stage may take a word when it is empty or its word moves on.
    always_comb
    begin
        rdy[epe_pkg::NSTAGE] = !valid_reg[epe_pkg::NSTAGE] || !result_stall;
        for (int i = epe_pkg::NSTAGE - 1; i >= 1; i--)
        begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
    end

    assign valid_in   = {valid_reg[epe_pkg::NSTAGE-1:1], item_valid};
    assign valid_next = (rdy & valid_in) | (~rdy & valid_reg);

    assign ctl.load    = rdy;
    assign item_stall   = !rdy[1];
    assign result_valid = valid_reg[epe_pkg::NSTAGE];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> ((&valid_reg) && result_stall))
        else $error("input stalled while the pipeline has a free stage");

    a_last_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[epe_pkg::NSTAGE] && !result_stall)
            |=> (valid_reg[epe_pkg::NSTAGE] == $past(valid_reg[epe_pkg::NSTAGE-1])))
        else $error("last stage did not take the word behind it");

    a_no_loss_under_stall: assert property (@(posedge clk) disable iff (!rst_n)
        result_stall |=> ($countones(valid_reg) >= $past($countones(valid_reg))))
        else $error("a word vanished while the output was stalled");
`endif

endmodule

// File: hw/rtl/epe_front.sv
module epe_front (
    input  logic                clk,
    input  epe_pkg::stage_ctl_t ctl,
    input  epe_pkg::cfg_t       cfg,
    input  epe_pkg::item_t      item,
    output epe_pkg::mid_t       mid
);

    logic signed [epe_pkg::TS_W:0]   dt_s;
    logic signed [epe_pkg::DRAG_W:0] drag_s;
    epe_pkg::fix_t                   p_in [3];
    epe_pkg::fix_t                   v_in [3];
    epe_pkg::fix_t                   w_in [3];

    // Stage 1: gravity scale, velocity relative to wind, position and life products.
    epe_pkg::fix_t                       k_reg, k_next;
    epe_pkg::fix_t                       dv_reg [3];
    epe_pkg::fix_t                       dv_next [3];
    logic signed [epe_pkg::PP_W-1:0]     pp_reg [3];
    logic signed [epe_pkg::PP_W-1:0]     pp_next [3];
    logic [epe_pkg::PL_W-1:0]            pl_reg, pl_next;
    epe_pkg::fix_t                       p1_reg [3];
    epe_pkg::fix_t                       v1_reg [3];
    epe_pkg::fix_t                       life1_reg;
    logic                                clip1_reg, clip1_next;

    // Stage 2: new positions and life, gravity and drag products.
    epe_pkg::fix_t                       np2_reg [3];
    epe_pkg::fix_t                       np2_next [3];
    epe_pkg::fix_t                       nl2_reg, nl2_next;
    logic signed [epe_pkg::PG_W-1:0]     pg_reg, pg_next;
    logic signed [epe_pkg::PD_W-1:0]     pd_reg [3];
    logic signed [epe_pkg::PD_W-1:0]     pd_next [3];
    epe_pkg::fix_t                       v2_reg [3];
    logic                                clip2_reg, clip2_next;

    // Stage 3: acceleration and bounce decision.
    epe_pkg::mid_t                       mid_reg, mid_next;

    assign dt_s   = $signed({1'b0, cfg.time_step});
    assign drag_s = $signed({1'b0, cfg.drag_gain});

    assign p_in[0] = item.pos_x;
    assign p_in[1] = item.pos_y;
    assign p_in[2] = item.pos_z;
    assign v_in[0] = item.vel_x;
    assign v_in[1] = item.vel_y;
    assign v_in[2] = item.vel_z;
    assign w_in[0] = cfg.wind_x;
    assign w_in[1] = cfg.wind_y;
    assign w_in[2] = cfg.wind_z;

    always_comb
    begin
        epe_pkg::sat_t  ks;
        epe_pkg::sat_t  ds;
        epe_pkg::wide_t lw;
        lw = epe_pkg::wide_t'(item.life_left);
        // 1 - 1.5 * life, with 1.5 * life rounded half up.
        ks = epe_pkg::sat_fix(epe_pkg::WIDE_ONE
                - ((lw + lw + lw + epe_pkg::wide_t'(1)) >>> 1));
        k_next     = ks.val;
        clip1_next = ks.clip;
        for (int i = 0; i < 3; i++)
        begin
            ds = epe_pkg::sat_fix(epe_pkg::wide_t'(v_in[i]) - epe_pkg::wide_t'(w_in[i]));
            dv_next[i] = ds.val;
            clip1_next = clip1_next | ds.clip;
            pp_next[i] = v_in[i] * dt_s;
        end
        pl_next = item.aging_rate * cfg.time_step;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[1])
        begin
            k_reg     <= k_next;
            dv_reg    <= dv_next;
            pp_reg    <= pp_next;
            pl_reg    <= pl_next;
            p1_reg    <= p_in;
            v1_reg    <= v_in;
            life1_reg <= item.life_left;
            clip1_reg <= clip1_next;
        end
    end

    always_comb
    begin
        epe_pkg::sat_t r;
        epe_pkg::sat_t s;
        clip2_next = clip1_reg;
        for (int i = 0; i < 3; i++)
        begin
            r = epe_pkg::round_sat(epe_pkg::wide_t'(pp_reg[i]));
            s = epe_pkg::sat_fix(epe_pkg::wide_t'(p1_reg[i]) + epe_pkg::wide_t'(r.val));
            np2_next[i] = s.val;
            clip2_next  = clip2_next | r.clip | s.clip;
            pd_next[i]  = drag_s * dv_reg[i];
        end
        r = epe_pkg::round_sat(epe_pkg::wide_t'(pl_reg));
        s = epe_pkg::sat_fix(epe_pkg::wide_t'(life1_reg) - epe_pkg::wide_t'(r.val));
        nl2_next   = s.val;
        clip2_next = clip2_next | r.clip | s.clip;
        pg_next    = k_reg * cfg.gravity_y;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[2])
        begin
            np2_reg   <= np2_next;
            nl2_reg   <= nl2_next;
            pg_reg    <= pg_next;
            pd_reg    <= pd_next;
            v2_reg    <= v1_reg;
            clip2_reg <= clip2_next;
        end
    end

    always_comb
    begin
        epe_pkg::sat_t g;
        epe_pkg::sat_t mx;
        epe_pkg::sat_t my;
        epe_pkg::sat_t mz;
        epe_pkg::sat_t ax;
        epe_pkg::sat_t ay;
        epe_pkg::sat_t az;
        epe_pkg::sat_t gd;
        logic          hit;
        g  = epe_pkg::round_sat(epe_pkg::wide_t'(pg_reg));
        mx = epe_pkg::round_sat(epe_pkg::wide_t'(pd_reg[0]));
        my = epe_pkg::round_sat(epe_pkg::wide_t'(pd_reg[1]));
        mz = epe_pkg::round_sat(epe_pkg::wide_t'(pd_reg[2]));
        ax = epe_pkg::sat_fix(-epe_pkg::wide_t'(mx.val));
        ay = epe_pkg::sat_fix(epe_pkg::wide_t'(g.val) - epe_pkg::wide_t'(my.val));
        az = epe_pkg::sat_fix(-epe_pkg::wide_t'(mz.val));
        hit = (np2_reg[1] <= cfg.ground_level);
        gd  = epe_pkg::sat_fix(epe_pkg::wide_t'(cfg.ground_level)
                               - epe_pkg::wide_t'(np2_reg[1]));

        mid_next.pos_x  = np2_reg[0];
        mid_next.pos_y  = np2_reg[1];
        mid_next.pos_z  = np2_reg[2];
        mid_next.vel_x  = v2_reg[0];
        mid_next.vel_y  = v2_reg[1];
        mid_next.vel_z  = v2_reg[2];
        mid_next.acc_x  = ax.val;
        mid_next.acc_y  = ay.val;
        mid_next.acc_z  = az.val;
        mid_next.life   = nl2_reg;
        mid_next.gdiff  = gd.val;
        mid_next.bounce = hit;
        // The overshoot is only used on a bounce, so only then does its clip count.
        mid_next.clip   = clip2_reg | g.clip | mx.clip | my.clip | mz.clip
                        | ax.clip | ay.clip | az.clip | (hit & gd.clip);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[3])
        begin
            mid_reg <= mid_next;
        end
    end

    assign mid = mid_reg;

endmodule

// File: hw/rtl/epe_back.sv
module epe_back (
    input  logic                clk,
    input  epe_pkg::stage_ctl_t ctl,
    input  epe_pkg::cfg_t       cfg,
    input  epe_pkg::mid_t       mid,
    output epe_pkg::result_t    result
);

    logic signed [epe_pkg::TS_W:0]   dt_s;
    logic signed [epe_pkg::REST_W:0] rest_s;
    logic signed [epe_pkg::REST_W:0] rest_neg;
    epe_pkg::fix_t                   a_in [3];

    // Stage 4: acceleration times step.
    epe_pkg::mid_t                   m4_reg;
    logic signed [epe_pkg::PP_W-1:0] pa_reg [3];
    logic signed [epe_pkg::PP_W-1:0] pa_next [3];

    // Stage 5: new velocities.
    epe_pkg::mid_t                   m5_reg, m5_next;
    epe_pkg::fix_t                   nv5_reg [3];
    epe_pkg::fix_t                   nv5_next [3];

    // Stage 6: bounce products.
    epe_pkg::mid_t                   m6_reg;
    epe_pkg::fix_t                   nv6_reg [3];
    logic signed [epe_pkg::PB_W-1:0] pbv_reg, pbv_next;
    logic signed [epe_pkg::PB_W-1:0] pbp_reg, pbp_next;

    // Stage 7: output register.
    epe_pkg::result_t                res_reg, res_next;

    assign dt_s     = $signed({1'b0, cfg.time_step});
    assign rest_s   = $signed({1'b0, cfg.bounce_restitution});
    assign rest_neg = -rest_s;

    assign a_in[0] = mid.acc_x;
    assign a_in[1] = mid.acc_y;
    assign a_in[2] = mid.acc_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pa_next[i] = a_in[i] * dt_s;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[4])
        begin
            m4_reg <= mid;
            pa_reg <= pa_next;
        end
    end

    always_comb
    begin
        epe_pkg::sat_t r;
        epe_pkg::sat_t s;
        epe_pkg::fix_t v [3];
        v[0] = m4_reg.vel_x;
        v[1] = m4_reg.vel_y;
        v[2] = m4_reg.vel_z;
        m5_next = m4_reg;
        for (int i = 0; i < 3; i++)
        begin
            r = epe_pkg::round_sat(epe_pkg::wide_t'(pa_reg[i]));
            s = epe_pkg::sat_fix(epe_pkg::wide_t'(v[i]) + epe_pkg::wide_t'(r.val));
            nv5_next[i]  = s.val;
            m5_next.clip = m5_next.clip | r.clip | s.clip;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[5])
        begin
            m5_reg  <= m5_next;
            nv5_reg <= nv5_next;
        end
    end

    assign pbv_next = nv5_reg[1] * rest_neg;
    assign pbp_next = rest_s * m5_reg.gdiff;

    always_ff @(posedge clk)
    begin
        if (ctl.load[6])
        begin
            m6_reg  <= m5_reg;
            nv6_reg <= nv5_reg;
            pbv_reg <= pbv_next;
            pbp_reg <= pbp_next;
        end
    end

    always_comb
    begin
        epe_pkg::sat_t rv;
        epe_pkg::sat_t rp;
        epe_pkg::sat_t s;
        rv = epe_pkg::round_sat(epe_pkg::wide_t'(pbv_reg));
        rp = epe_pkg::round_sat(epe_pkg::wide_t'(pbp_reg));
        s  = epe_pkg::sat_fix(epe_pkg::wide_t'(cfg.ground_level) + epe_pkg::wide_t'(rp.val));

        res_next.new_pos_x = m6_reg.pos_x;
        res_next.new_pos_y = m6_reg.pos_y;
        res_next.new_pos_z = m6_reg.pos_z;
        res_next.new_vel_x = nv6_reg[0];
        res_next.new_vel_y = nv6_reg[1];
        res_next.new_vel_z = nv6_reg[2];
        res_next.new_life  = m6_reg.life;
        res_next.bounced   = m6_reg.bounce;
        res_next.saturated = m6_reg.clip;
        // On a bounce, reverse and damp the vertical speed and mirror the overshoot.
        if (m6_reg.bounce)
        begin
            res_next.new_vel_y = rv.val;
            res_next.new_pos_y = s.val;
            res_next.saturated = m6_reg.clip | rv.clip | rp.clip | s.clip;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[7])
        begin
            res_reg <= res_next;
        end
    end

    assign result = res_reg;

endmodule

// File: hw/rtl/particle_euler_step.sv
// One explicit Euler step per particle in signed Q16.16: position, velocity
// and remaining life are advanced by time_step, with gravity scaled by
// (1 - 1.5*life), drag against the wind, and a damped bounce at ground_level.
// The datapath is a seven-stage pipeline that takes a new word every cycle
// unless the input stalls. The output register holds a stalled result
// while earlier stages keep filling; the input stalls only when all seven
// stages are occupied and the output is stalled. Any clipped intermediate
// that is used, or a clipped result, sets the saturated flag. The
// configuration registers are always ready and should be written only while
// no particle is in flight.
module particle_euler_step (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  epe_pkg::item_t                item,
    output logic                          result_valid,
    input  logic                          result_stall,
    output epe_pkg::result_t              result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [epe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [epe_pkg::DATA_W-1:0]    cfg_data
);

    epe_pkg::cfg_t       cfg;
    epe_pkg::stage_ctl_t ctl;
    epe_pkg::mid_t       mid;

    epe_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    epe_pipe_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .ctl          (ctl)
    );

    epe_front u_front (
        .clk  (clk),
        .ctl  (ctl),
        .cfg  (cfg),
        .item (item),
        .mid  (mid)
    );

    epe_back u_back (
        .clk    (clk),
        .ctl    (ctl),
        .cfg    (cfg),
        .mid    (mid),
        .result (result)
    );

`ifndef SYNTHESIS
    a_bounce_above_ground: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.bounced) |-> (result.new_pos_y >= cfg.ground_level))
        else $error("bounced particle left below the ground plane");
`endif

endmodule
